FILE: design/assert_macros.svh
// Assertion helpers included by the filter design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define KF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true
`define KF3_NEVER(lbl, cond, msg) \
  `KF3_ASSERT(lbl, !(cond), msg)

`endif

FILE: design/kf3_pkg.sv
package kf3_pkg;

  // operation codes
  localparam logic [1:0] OPC_INIT    = 2'd0;
  localparam logic [1:0] OPC_PREDICT = 2'd1;
  localparam logic [1:0] OPC_UPDATE  = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOINIT   = 2'd1;
  localparam logic [1:0] STS_BADPARAM = 2'd2;
  localparam logic [1:0] STS_REJECT   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_INIT_POS_VAR = 3'd0;
  localparam logic [2:0] REG_INIT_VEL_VAR = 3'd1;
  localparam logic [2:0] REG_INIT_BIAS_VAR = 3'd2;
  localparam logic [2:0] REG_ACCEL_NOISE  = 3'd3;
  localparam logic [2:0] REG_BIAS_WALK    = 3'd4;
  localparam logic [2:0] REG_MEAS_NOISE   = 3'd5;
  localparam logic [2:0] REG_GATE         = 3'd6;
  localparam logic [2:0] REG_MAX_STEP     = 3'd7;

  // micro-operations
  localparam logic [3:0] OP_LDK  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MOV  = 4'd3;
  localparam logic [3:0] OP_FIXS = 4'd4;
  localparam logic [3:0] OP_MUL  = 4'd5;
  localparam logic [3:0] OP_SQE  = 4'd6;
  localparam logic [3:0] OP_GATE = 4'd7;
  localparam logic [3:0] OP_DIV  = 4'd8;
  localparam logic [3:0] OP_OUT1 = 4'd9;
  localparam logic [3:0] OP_OUT2 = 4'd10;
  localparam logic [3:0] OP_OUT3 = 4'd11;
  localparam logic [3:0] OP_DONE = 4'd12;
  localparam logic [3:0] OP_JOUT = 4'd13;

  // state memory map
  localparam logic [5:0] A_POS  = 6'd0;
  localparam logic [5:0] A_VEL  = 6'd1;
  localparam logic [5:0] A_BIAS = 6'd2;
  localparam logic [5:0] A_C0   = 6'd3;
  localparam logic [5:0] A_C1   = 6'd4;
  localparam logic [5:0] A_C2   = 6'd5;
  localparam logic [5:0] A_C3   = 6'd6;
  localparam logic [5:0] A_C4   = 6'd7;
  localparam logic [5:0] A_C5   = 6'd8;
  localparam logic [5:0] A_DT   = 6'd9;
  localparam logic [5:0] A_ACC  = 6'd10;
  localparam logic [5:0] A_DT2  = 6'd11;
  localparam logic [5:0] A_H    = 6'd12;
  localparam logic [5:0] A_DTH  = 6'd13;
  localparam logic [5:0] A_HH   = 6'd14;
  localparam logic [5:0] A_DT3  = 6'd15;
  localparam logic [5:0] A_DT4  = 6'd16;
  localparam logic [5:0] A_Q    = 6'd17;
  localparam logic [5:0] A_W    = 6'd18;
  localparam logic [5:0] A_T    = 6'd19;
  localparam logic [5:0] A_T2   = 6'd20;
  localparam logic [5:0] A_N00  = 6'd21;
  localparam logic [5:0] A_N01  = 6'd22;
  localparam logic [5:0] A_N02  = 6'd23;
  localparam logic [5:0] A_N11  = 6'd24;
  localparam logic [5:0] A_N12  = 6'd25;
  localparam logic [5:0] A_N22  = 6'd26;
  localparam logic [5:0] A_K0   = 6'd27;
  localparam logic [5:0] A_K1   = 6'd28;
  localparam logic [5:0] A_K2   = 6'd29;
  localparam logic [5:0] A_E    = 6'd30;
  localparam logic [5:0] A_S    = 6'd31;
  localparam logic [5:0] A_OMK  = 6'd32;

  // constant selectors for OP_LDK
  localparam logic [5:0] K_DT    = 6'd0;
  localparam logic [5:0] K_ACC   = 6'd1;
  localparam logic [5:0] K_Z     = 6'd2;
  localparam logic [5:0] K_VEL0  = 6'd3;
  localparam logic [5:0] K_HALF  = 6'd4;
  localparam logic [5:0] K_QUART = 6'd5;
  localparam logic [5:0] K_ONE   = 6'd6;
  localparam logic [5:0] K_Q     = 6'd7;
  localparam logic [5:0] K_W     = 6'd8;
  localparam logic [5:0] K_R     = 6'd9;
  localparam logic [5:0] K_IPV   = 6'd10;
  localparam logic [5:0] K_IVV   = 6'd11;
  localparam logic [5:0] K_IBV   = 6'd12;
  localparam logic [5:0] K_ZERO  = 6'd13;

  // program entry points
  localparam logic [6:0] PC_GATHER  = 7'd0;
  localparam logic [6:0] PC_INIT    = 7'd4;
  localparam logic [6:0] PC_PREDICT = 7'd14;
  localparam logic [6:0] PC_UPDATE  = 7'd84;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
  } uop_t;

  function automatic uop_t mk(logic [3:0] op, logic [5:0] dst, logic [5:0] sa,
                              logic [5:0] sb);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.sa = sa;
    u.sb = sb;
    return u;
  endfunction

  // microprogram store
  function automatic uop_t ucode(logic [6:0] pc);
    uop_t u;
    unique case (pc)
      // result gather, shared by all paths
      7'd0:  u = mk(OP_OUT1, A_T, A_POS, A_VEL);
      7'd1:  u = mk(OP_OUT2, A_T, A_BIAS, A_C0);
      7'd2:  u = mk(OP_OUT3, A_T, A_C3, A_C5);
      7'd3:  u = mk(OP_DONE, A_T, A_T, A_T);
      // init
      7'd4:  u = mk(OP_LDK, A_POS, K_Z, A_T);
      7'd5:  u = mk(OP_LDK, A_VEL, K_VEL0, A_T);
      7'd6:  u = mk(OP_LDK, A_BIAS, K_ZERO, A_T);
      7'd7:  u = mk(OP_LDK, A_C0, K_IPV, A_T);
      7'd8:  u = mk(OP_LDK, A_C1, K_ZERO, A_T);
      7'd9:  u = mk(OP_LDK, A_C2, K_ZERO, A_T);
      7'd10: u = mk(OP_LDK, A_C3, K_IVV, A_T);
      7'd11: u = mk(OP_LDK, A_C4, K_ZERO, A_T);
      7'd12: u = mk(OP_LDK, A_C5, K_IBV, A_T);
      7'd13: u = mk(OP_JOUT, A_T, A_T, A_T);
      // predict: state
      7'd14: u = mk(OP_LDK, A_DT, K_DT, A_T);
      7'd15: u = mk(OP_LDK, A_T, K_ACC, A_T);
      7'd16: u = mk(OP_SUB, A_ACC, A_T, A_BIAS);
      7'd17: u = mk(OP_MUL, A_DT2, A_DT, A_DT);
      7'd18: u = mk(OP_LDK, A_T, K_HALF, A_T);
      7'd19: u = mk(OP_MUL, A_H, A_T, A_DT2);
      7'd20: u = mk(OP_MUL, A_T, A_VEL, A_DT);
      7'd21: u = mk(OP_MUL, A_T2, A_ACC, A_H);
      7'd22: u = mk(OP_ADD, A_T, A_T, A_T2);
      7'd23: u = mk(OP_ADD, A_POS, A_POS, A_T);
      7'd24: u = mk(OP_MUL, A_T, A_ACC, A_DT);
      7'd25: u = mk(OP_ADD, A_VEL, A_VEL, A_T);
      7'd26: u = mk(OP_LDK, A_Q, K_Q, A_T);
      7'd27: u = mk(OP_LDK, A_W, K_W, A_T);
      7'd28: u = mk(OP_MUL, A_DTH, A_DT, A_H);
      7'd29: u = mk(OP_MUL, A_HH, A_H, A_H);
      7'd30: u = mk(OP_MUL, A_DT3, A_DT, A_DT2);
      7'd31: u = mk(OP_MUL, A_DT4, A_DT2, A_DT2);
      // predict: P00
      7'd32: u = mk(OP_MUL, A_T, A_DT, A_C1);
      7'd33: u = mk(OP_ADD, A_T, A_T, A_T);
      7'd34: u = mk(OP_ADD, A_N00, A_C0, A_T);
      7'd35: u = mk(OP_MUL, A_T, A_H, A_C2);
      7'd36: u = mk(OP_ADD, A_T, A_T, A_T);
      7'd37: u = mk(OP_SUB, A_N00, A_N00, A_T);
      7'd38: u = mk(OP_MUL, A_T, A_DT2, A_C3);
      7'd39: u = mk(OP_ADD, A_N00, A_N00, A_T);
      7'd40: u = mk(OP_MUL, A_T, A_DTH, A_C4);
      7'd41: u = mk(OP_ADD, A_T, A_T, A_T);
      7'd42: u = mk(OP_SUB, A_N00, A_N00, A_T);
      7'd43: u = mk(OP_MUL, A_T, A_HH, A_C5);
      7'd44: u = mk(OP_ADD, A_N00, A_N00, A_T);
      7'd45: u = mk(OP_LDK, A_T, K_QUART, A_T);
      7'd46: u = mk(OP_MUL, A_T, A_T, A_Q);
      7'd47: u = mk(OP_MUL, A_T, A_T, A_DT4);
      7'd48: u = mk(OP_ADD, A_N00, A_N00, A_T);
      // predict: P01
      7'd49: u = mk(OP_MUL, A_T, A_DT, A_C2);
      7'd50: u = mk(OP_SUB, A_N01, A_C1, A_T);
      7'd51: u = mk(OP_MUL, A_T, A_DT, A_C3);
      7'd52: u = mk(OP_ADD, A_N01, A_N01, A_T);
      7'd53: u = mk(OP_ADD, A_T, A_H, A_DT2);
      7'd54: u = mk(OP_MUL, A_T, A_T, A_C4);
      7'd55: u = mk(OP_SUB, A_N01, A_N01, A_T);
      7'd56: u = mk(OP_MUL, A_T, A_DTH, A_C5);
      7'd57: u = mk(OP_ADD, A_N01, A_N01, A_T);
      7'd58: u = mk(OP_LDK, A_T, K_HALF, A_T);
      7'd59: u = mk(OP_MUL, A_T, A_T, A_Q);
      7'd60: u = mk(OP_MUL, A_T, A_T, A_DT3);
      7'd61: u = mk(OP_ADD, A_N01, A_N01, A_T);
      // predict: P02, P11, P12, P22
      7'd62: u = mk(OP_MUL, A_T, A_DT, A_C4);
      7'd63: u = mk(OP_ADD, A_N02, A_C2, A_T);
      7'd64: u = mk(OP_MUL, A_T, A_H, A_C5);
      7'd65: u = mk(OP_SUB, A_N02, A_N02, A_T);
      7'd66: u = mk(OP_MUL, A_T, A_DT, A_C4);
      7'd67: u = mk(OP_ADD, A_T, A_T, A_T);
      7'd68: u = mk(OP_SUB, A_N11, A_C3, A_T);
      7'd69: u = mk(OP_MUL, A_T, A_DT2, A_C5);
      7'd70: u = mk(OP_ADD, A_N11, A_N11, A_T);
      7'd71: u = mk(OP_MUL, A_T, A_Q, A_DT2);
      7'd72: u = mk(OP_ADD, A_N11, A_N11, A_T);
      7'd73: u = mk(OP_MUL, A_T, A_DT, A_C5);
      7'd74: u = mk(OP_SUB, A_N12, A_C4, A_T);
      7'd75: u = mk(OP_MUL, A_T, A_W, A_DT);
      7'd76: u = mk(OP_ADD, A_N22, A_C5, A_T);
      7'd77: u = mk(OP_MOV, A_C0, A_N00, A_T);
      7'd78: u = mk(OP_MOV, A_C1, A_N01, A_T);
      7'd79: u = mk(OP_MOV, A_C2, A_N02, A_T);
      7'd80: u = mk(OP_MOV, A_C3, A_N11, A_T);
      7'd81: u = mk(OP_MOV, A_C4, A_N12, A_T);
      7'd82: u = mk(OP_MOV, A_C5, A_N22, A_T);
      7'd83: u = mk(OP_JOUT, A_T, A_T, A_T);
      // update: innovation and gate
      7'd84: u = mk(OP_LDK, A_T, K_Z, A_T);
      7'd85: u = mk(OP_SUB, A_E, A_T, A_POS);
      7'd86: u = mk(OP_LDK, A_T, K_R, A_T);
      7'd87: u = mk(OP_ADD, A_S, A_C0, A_T);
      7'd88: u = mk(OP_FIXS, A_S, A_S, A_T);
      7'd89: u = mk(OP_SQE, A_T, A_E, A_T);
      7'd90: u = mk(OP_GATE, A_T, A_S, A_T);
      // update: gains and correction
      7'd91: u = mk(OP_DIV, A_K0, A_C0, A_S);
      7'd92: u = mk(OP_DIV, A_K1, A_C1, A_S);
      7'd93: u = mk(OP_DIV, A_K2, A_C2, A_S);
      7'd94: u = mk(OP_MUL, A_T, A_K0, A_E);
      7'd95: u = mk(OP_ADD, A_POS, A_POS, A_T);
      7'd96: u = mk(OP_MUL, A_T, A_K1, A_E);
      7'd97: u = mk(OP_ADD, A_VEL, A_VEL, A_T);
      7'd98: u = mk(OP_MUL, A_T, A_K2, A_E);
      7'd99: u = mk(OP_ADD, A_BIAS, A_BIAS, A_T);
      7'd100: u = mk(OP_LDK, A_T, K_ONE, A_T);
      7'd101: u = mk(OP_SUB, A_OMK, A_T, A_K0);
      7'd102: u = mk(OP_MUL, A_N00, A_OMK, A_C0);
      7'd103: u = mk(OP_MUL, A_N01, A_OMK, A_C1);
      7'd104: u = mk(OP_MUL, A_N02, A_OMK, A_C2);
      7'd105: u = mk(OP_MUL, A_T, A_K1, A_C1);
      7'd106: u = mk(OP_SUB, A_N11, A_C3, A_T);
      7'd107: u = mk(OP_MUL, A_T, A_K1, A_C2);
      7'd108: u = mk(OP_SUB, A_N12, A_C4, A_T);
      7'd109: u = mk(OP_MUL, A_T, A_K2, A_C2);
      7'd110: u = mk(OP_SUB, A_N22, A_C5, A_T);
      7'd111: u = mk(OP_MOV, A_C0, A_N00, A_T);
      7'd112: u = mk(OP_MOV, A_C1, A_N01, A_T);
      7'd113: u = mk(OP_MOV, A_C2, A_N02, A_T);
      7'd114: u = mk(OP_MOV, A_C3, A_N11, A_T);
      7'd115: u = mk(OP_MOV, A_C4, A_N12, A_T);
      7'd116: u = mk(OP_MOV, A_C5, A_N22, A_T);
      7'd117: u = mk(OP_JOUT, A_T, A_T, A_T);
      default: u = mk(OP_JOUT, A_T, A_T, A_T);
    endcase
    return u;
  endfunction

endpackage

FILE: design/kf3_if.sv
// Command channel: one filter operation per item
interface kf3_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] accel_sample;
  logic [23:0]        time_step;
  logic signed [39:0] position_sample;
  logic signed [31:0] initial_velocity;

  modport source (output valid, operation, accel_sample, time_step, position_sample,
                  initial_velocity, input ready);
  modport sink (input valid, operation, accel_sample, time_step, position_sample,
                initial_velocity, output ready);
endinterface

// Result channel: one item per command
interface kf3_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               initialized;
  logic signed [63:0] position_estimate;
  logic signed [63:0] velocity_estimate;
  logic signed [63:0] bias_estimate;
  logic signed [63:0] position_var_out;
  logic signed [63:0] velocity_var_out;
  logic signed [63:0] bias_var_out;
  logic [31:0]        reject_count;

  modport source (output valid, status, initialized, position_estimate, velocity_estimate,
                  bias_estimate, position_var_out, velocity_var_out, bias_var_out,
                  reject_count, input ready);
  modport sink (input valid, status, initialized, position_estimate, velocity_estimate,
                bias_estimate, position_var_out, velocity_var_out, bias_var_out,
                reject_count, output ready);
endinterface

FILE: design/three_state_kalman_nav_filter.sv
// One-axis position / velocity / accelerometer-bias Kalman filter, Q32.32.
// cmd: one item per operation (init, predict, position update); res: one
// item per command with status, estimates, variances and reject count.
// Configuration is written through the APB port (8-byte register stride);
// the user writes it only while the block is idle; the block does not enforce this.
// Datapath: a microprogram runs on a shared 32x32 multiplier for Q32.32
// products and a one-bit-per-cycle divider, with all state in a two-read,
// one-write memory. One item is processed at a time; cmd is ready again
// once the result is in the output register.
// Reset clears the registers to their defaults and marks the filter
// uninitialized; the state memory is not cleared, outputs read zero until
// a valid init. If res stalls, the finished result waits in the output
// register, the next command may be accepted and runs up to its final
// step, where it waits for the register to free.
module three_state_kalman_nav_filter (
  input  logic             clk,
  input  logic             rst,
  kf3_cmd_if.sink          cmd,
  kf3_res_if.source        res,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import kf3_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_MWB   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DWB   = 3'd6;

  // configuration registers
  logic [62:0] init_position_var, init_velocity_var, init_bias_var;
  logic [62:0] accel_noise_var, bias_walk_var, meas_noise_var;
  logic [15:0] gate_sigma_sq;
  logic [23:0] max_time_step;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_position_var <= 63'h1_0000_0000;
      init_velocity_var <= 63'h1_0000_0000;
      init_bias_var     <= 63'h1_0000_0000;
      accel_noise_var   <= 63'h1_0000_0000;
      bias_walk_var     <= '0;
      meas_noise_var    <= 63'h1_0000_0000;
      gate_sigma_sq     <= 16'd2304;
      max_time_step     <= 24'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_INIT_POS_VAR:  init_position_var <= pwdata[62:0];
        REG_INIT_VEL_VAR:  init_velocity_var <= pwdata[62:0];
        REG_INIT_BIAS_VAR: init_bias_var     <= pwdata[62:0];
        REG_ACCEL_NOISE:   accel_noise_var   <= pwdata[62:0];
        REG_BIAS_WALK:     bias_walk_var     <= pwdata[62:0];
        REG_MEAS_NOISE:    meas_noise_var    <= pwdata[62:0];
        REG_GATE:          gate_sigma_sq     <= pwdata[15:0];
        REG_MAX_STEP:      max_time_step     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[5:3])
      REG_INIT_POS_VAR:  prdata = {1'b0, init_position_var};
      REG_INIT_VEL_VAR:  prdata = {1'b0, init_velocity_var};
      REG_INIT_BIAS_VAR: prdata = {1'b0, init_bias_var};
      REG_ACCEL_NOISE:   prdata = {1'b0, accel_noise_var};
      REG_BIAS_WALK:     prdata = {1'b0, bias_walk_var};
      REG_MEAS_NOISE:    prdata = {1'b0, meas_noise_var};
      REG_GATE:          prdata = {48'd0, gate_sigma_sq};
      REG_MAX_STEP:      prdata = {40'd0, max_time_step};
      default:           prdata = '0;
    endcase
  end

  // arithmetic helpers
  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] from_mag(logic neg, logic [63:0] m);
    logic [63:0] r;
    if (!neg) r = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    else if (m[63]) r = 64'h8000_0000_0000_0000;
    else r = 64'd0 - m;
    return r;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic sub);
    logic [64:0] s;
    logic [63:0] r;
    if (sub) s = {a[63], a} - {b[63], b};
    else s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else r = s[63:0];
    return r;
  endfunction

  // control and datapath registers
  logic [2:0]   state;
  logic [6:0]   pc;
  logic [1:0]   sts;
  logic         ready_flag;
  logic [31:0]  rejects;
  logic signed [31:0] i_accel, i_vel;
  logic [23:0]  i_ts;
  logic signed [39:0] i_pos;

  logic [63:0]  mem [64];
  logic [63:0]  rda, rdb;
  logic         we;
  logic [5:0]   wa;
  logic [63:0]  wd;
  uop_t         u;

  logic [63:0]  ma, mb;
  logic         mneg;
  logic [1:0]   mcnt;
  logic [127:0] acc, acc_add, glhs;
  logic [63:0]  pp;
  logic [63:0]  mul_res, mul_r;

  logic [127:0] dvd;
  logic [63:0]  drem, dq, dd, div_remn, div_res, div_q2;
  logic         dovf, dneg;
  logic [6:0]   dcnt;

  logic [63:0]  o_pos, o_vel, o_bias, o_p00, o_p11, o_p22;
  logic         out_free, res_load;
  logic         init_bad, step_bad, reject_fix;
  logic [31:0]  g2;
  logic [63:0]  kval;

  assign u        = ucode(pc);
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !res.valid || res.ready;
  assign res_load = (state == S_EXEC) && (u.op == OP_DONE) && out_free;
  assign g2       = 32'(gate_sigma_sq) * 32'(gate_sigma_sq);
  assign init_bad = (init_position_var == '0) || (init_velocity_var == '0) ||
                    (init_bias_var == '0) || (accel_noise_var == '0) ||
                    (meas_noise_var == '0) || (gate_sigma_sq == '0);
  assign step_bad = (cmd.time_step == '0) || (cmd.time_step > max_time_step);
  assign reject_fix = glhs > {acc[111:0], 16'd0};

  // constant operands
  always_comb begin
    unique case (u.sa)
      K_DT:    kval = {24'd0, i_ts, 16'd0};
      K_ACC:   kval = {{16{i_accel[31]}}, i_accel, 16'd0};
      K_Z:     kval = {{8{i_pos[39]}}, i_pos, 16'd0};
      K_VEL0:  kval = {{16{i_vel[31]}}, i_vel, 16'd0};
      K_HALF:  kval = 64'h0000_0000_8000_0000;
      K_QUART: kval = 64'h0000_0000_4000_0000;
      K_ONE:   kval = 64'h0000_0001_0000_0000;
      K_Q:     kval = {1'b0, accel_noise_var};
      K_W:     kval = {1'b0, bias_walk_var};
      K_R:     kval = {1'b0, meas_noise_var};
      K_IPV:   kval = {1'b0, init_position_var};
      K_IVV:   kval = {1'b0, init_velocity_var};
      K_IBV:   kval = {1'b0, init_bias_var};
      default: kval = '0;
    endcase
  end

  // multiplier: one 32x32 partial product per cycle
  always_comb begin
    unique case (mcnt)
      2'd0: pp = ma[31:0] * mb[31:0];
      2'd1: pp = ma[31:0] * mb[63:32];
      2'd2: pp = ma[63:32] * mb[31:0];
      default: pp = ma[63:32] * mb[63:32];
    endcase
    unique case (mcnt)
      2'd0: acc_add = {64'd0, pp};
      2'd1, 2'd2: acc_add = {32'd0, pp, 32'd0};
      default: acc_add = {pp, 64'd0};
    endcase
  end

  // Q32.32 product: round half away from zero, saturate
  always_comb begin
    if (acc[127:96] != '0) mul_r = '1;
    else if (acc[95]) mul_r = acc[95:32];
    else mul_r = acc[95:32] + 64'(acc[31]);
    mul_res = from_mag(mneg, mul_r);
  end

  // divider step and final rounding
  always_comb begin
    div_remn = {drem[62:0], dvd[127]};
    div_q2 = (drem >= (dd - drem)) ? dq + 64'd1 : dq;
    if (dovf || dq[63]) div_res = from_mag(dneg, '1);
    else div_res = from_mag(dneg, div_q2);
  end

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = u.dst;
    wd = '0;
    if (state == S_EXEC) begin
      unique case (u.op)
        OP_LDK:  begin we = 1'b1; wd = kval; end
        OP_ADD:  begin we = 1'b1; wd = sat_add(rda, rdb, 1'b0); end
        OP_SUB:  begin we = 1'b1; wd = sat_add(rda, rdb, 1'b1); end
        OP_MOV:  begin we = 1'b1; wd = rda; end
        OP_FIXS: begin we = 1'b1; wd = (rda[63] || rda == '0) ? 64'd1 : rda; end
        default: ;
      endcase
    end else if (state == S_MWB && u.op == OP_MUL) begin
      we = 1'b1;
      wd = mul_res;
    end else if (state == S_DWB) begin
      we = 1'b1;
      wd = div_res;
    end
  end

  // state memory; reads are registered, so each op sees in S_FETCH what the previous op wrote
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rda <= mem[u.sa];
    rdb <= mem[u.sb];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= PC_GATHER;
      ready_flag <= 1'b0;
      rejects    <= '0;
      res.valid  <= 1'b0;
      sts        <= STS_OK;
    end else begin
      if (res.valid && res.ready && !res_load) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            i_accel <= cmd.accel_sample;
            i_ts    <= cmd.time_step;
            i_pos   <= cmd.position_sample;
            i_vel   <= cmd.initial_velocity;
            state   <= S_FETCH;
            if (cmd.operation == OPC_INIT) begin
              if (init_bad) begin
                ready_flag <= 1'b0;
                sts        <= STS_BADPARAM;
                pc         <= PC_GATHER;
              end else begin
                ready_flag <= 1'b1;
                rejects    <= '0;
                sts        <= STS_OK;
                pc         <= PC_INIT;
              end
            end else if (cmd.operation != OPC_PREDICT && cmd.operation != OPC_UPDATE) begin
              sts <= STS_BADPARAM;
              pc  <= PC_GATHER;
            end else if (!ready_flag) begin
              sts <= STS_NOINIT;
              pc  <= PC_GATHER;
            end else if (cmd.operation == OPC_PREDICT) begin
              if (step_bad) begin
                sts <= STS_BADPARAM;
                pc  <= PC_GATHER;
              end else begin
                sts <= STS_OK;
                pc  <= PC_PREDICT;
              end
            end else begin
              sts <= STS_OK;
              pc  <= PC_UPDATE;
            end
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          unique case (u.op)
            OP_MUL, OP_SQE, OP_GATE: begin
              acc   <= '0;
              mcnt  <= '0;
              state <= S_MUL;
              if (u.op == OP_MUL) begin
                ma   <= mag(rda);
                mb   <= mag(rdb);
                mneg <= rda[63] ^ rdb[63];
              end else if (u.op == OP_SQE) begin
                ma   <= mag(rda);
                mb   <= mag(rda);
                mneg <= 1'b0;
              end else begin
                ma   <= {32'd0, g2};
                mb   <= rda;
                mneg <= 1'b0;
              end
            end
            OP_DIV: begin
              dvd   <= {32'd0, mag(rda), 32'd0};
              dd    <= rdb;
              dneg  <= rda[63];
              drem  <= '0;
              dq    <= '0;
              dovf  <= 1'b0;
              dcnt  <= '0;
              state <= S_DIV;
            end
            OP_OUT1: begin
              o_pos <= rda;
              o_vel <= rdb;
              state <= S_FETCH;
              pc    <= pc + 7'd1;
            end
            OP_OUT2: begin
              o_bias <= rda;
              o_p00  <= rdb;
              state  <= S_FETCH;
              pc     <= pc + 7'd1;
            end
            OP_OUT3: begin
              o_p11 <= rda;
              o_p22 <= rdb;
              state <= S_FETCH;
              pc    <= pc + 7'd1;
            end
            OP_JOUT: begin
              state <= S_FETCH;
              pc    <= PC_GATHER;
            end
            OP_DONE: begin
              // wait here until the output register frees
              if (out_free) begin
                res.valid             <= 1'b1;
                res.status            <= sts;
                res.initialized       <= ready_flag;
                res.position_estimate <= ready_flag ? o_pos : '0;
                res.velocity_estimate <= ready_flag ? o_vel : '0;
                res.bias_estimate     <= ready_flag ? o_bias : '0;
                res.position_var_out  <= ready_flag ? o_p00 : '0;
                res.velocity_var_out  <= ready_flag ? o_p11 : '0;
                res.bias_var_out      <= ready_flag ? o_p22 : '0;
                res.reject_count      <= rejects;
                state                 <= S_IDLE;
              end
            end
            default: begin
              state <= S_FETCH;
              pc    <= pc + 7'd1;
            end
          endcase
        end
        S_MUL: begin
          acc  <= acc + acc_add;
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) state <= S_MWB;
        end
        S_MWB: begin
          state <= S_FETCH;
          if (u.op == OP_SQE) glhs <= acc;
          if (u.op == OP_GATE && reject_fix) begin
            if (rejects != '1) rejects <= rejects + 32'd1;
            sts <= STS_REJECT;
            pc  <= PC_GATHER;
          end else begin
            pc <= pc + 7'd1;
          end
        end
        S_DIV: begin
          dvd <= {dvd[126:0], 1'b0};
          if (dq[63]) dovf <= 1'b1;
          if (div_remn >= dd) begin
            drem <= div_remn - dd;
            dq   <= {dq[62:0], 1'b1};
          end else begin
            drem <= div_remn;
            dq   <= {dq[62:0], 1'b0};
          end
          dcnt <= dcnt + 7'd1;
          if (dcnt == '1) state <= S_DWB;
        end
        S_DWB: begin
          state <= S_FETCH;
          pc    <= pc + 7'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `KF3_ASSERT(a_res_from_done, $rose(res.valid) |-> $past(state) == S_EXEC && $past(u.op) == OP_DONE, "result raised outside final step")
  `KF3_NEVER(a_div_positive, state == S_DIV && (dd[63] || dd == '0), "divider sees a non-positive innovation variance")
  `KF3_ASSERT(a_uninit_zero, res.valid && !res.initialized |-> res.position_estimate == '0 && res.bias_var_out == '0, "uninitialized result carries state")
  `KF3_ASSERT(a_reject_status, res.valid && res.status == STS_REJECT |-> res.initialized, "fix rejected while uninitialized")

endmodule
